@@ rtl/assert_macros.svh @@
// ============================================================================
// Assertion macros
// Shared concurrent assertion wrappers for the blend engine RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, disabled while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed: cond -> prop");

// Implication whose consequent is checked in the cycle after the antecedent holds.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed: cond => prop");

`endif

@@ rtl/ipbe_pkg.sv @@
// ============================================================================
// ipbe_pkg
// Types, constants and helpers for the indexed pixel blend engine.
// ============================================================================
package ipbe_pkg;

    localparam int TABLE_COUNT   = 4;
    localparam int TABLE_ENTRIES = 256 * 256;
    localparam int RAM_DEPTH     = TABLE_COUNT * TABLE_ENTRIES;
    localparam int RAM_AW        = $clog2(RAM_DEPTH);
    localparam int PIX_W         = 8;

    typedef enum logic [1:0] {
        MODE_RAW   = 2'd0,
        MODE_KEY   = 2'd1,
        MODE_TRANS = 2'd2,
        MODE_XFADE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CFG_BLEND_MODE   = 2'd0,
        CFG_TABLE_SELECT = 2'd1,
        CFG_MASK_ENABLE  = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        OP_BLEND    = 1'b0,
        OP_TABLE_WR = 1'b1
    } t_opcode;

    typedef struct packed {
        t_mode      mode;
        logic [1:0] table_select;
        logic       mask_enable;
    } t_cfg;

    function automatic logic tbl_ok(input logic [1:0] t);
        return int'(t) < TABLE_COUNT;
    endfunction

    function automatic logic [RAM_AW-1:0] ram_addr(input logic [1:0] t,
                                                   input logic [PIX_W-1:0] row,
                                                   input logic [PIX_W-1:0] col);
        return RAM_AW'({t, row, col});
    endfunction

endpackage

@@ rtl/indexed_pixel_blend_engine_unit.sv @@
// ============================================================================
// indexed_pixel_blend_engine_unit
// Palette-index pixel blender with translucency lookup tables in one RAM.
// ============================================================================
// The block takes one request per cycle, blend or table write, with no
// bubbles unless stalled. A blend request delivers its result in the cycle
// after acceptance, from the single output register; table lookups use the
// one read port of the table RAM and its registered read data, and table
// writes use its write port in the cycle they are accepted, so a lookup may
// follow a write of the same entry in the very next cycle. Table writes are
// accepted even while a result waits at a stalled output; a blend request
// waits only when that result cannot leave. The table RAM has no reset and
// no clearing pass: an entry must be written before it is looked up.
`include "assert_macros.svh"

module indexed_pixel_blend_engine_unit import ipbe_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [1:0]       i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_in_opcode,
    input  logic [PIX_W-1:0] i_in_src_pixel,
    input  logic [PIX_W-1:0] i_in_dst_pixel,
    input  logic [PIX_W-1:0] i_in_object_pixel,
    input  logic             i_in_mask_bit,
    input  logic [1:0]       i_in_table_number,
    input  logic [PIX_W-1:0] i_in_table_value,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [PIX_W-1:0] o_out_pixel,
    output logic             o_out_written
);

    t_cfg              cfg;
    logic              in_acc;
    logic              is_wr;
    logic              blend_acc;
    logic              wr_en;
    logic              rd_en;
    logic [RAM_AW-1:0] wr_addr;
    logic [RAM_AW-1:0] rd_addr;
    logic [PIX_W-1:0]  rd_data;
    logic [PIX_W-1:0]  col;
    logic              use_lut;
    logic              do_write;
    logic [PIX_W-1:0]  pix;
    logic              src_hit;

    logic              r_s1_valid;
    logic              n_s1_valid;
    logic              r_s1_use_lut;
    logic              r_s1_written;
    logic [PIX_W-1:0]  r_s1_pix;

    ipbe_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign is_wr      = (i_in_opcode == OP_TABLE_WR);
    assign o_in_stall = r_s1_valid && i_out_stall && !is_wr;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign blend_acc  = in_acc && !is_wr;

    assign wr_en   = in_acc && is_wr && tbl_ok(i_in_table_number);
    assign wr_addr = ram_addr(i_in_table_number, i_in_src_pixel, i_in_dst_pixel);

    assign src_hit = (i_in_src_pixel != '0);

    always_comb begin
        do_write = 1'b0;
        use_lut  = 1'b0;
        pix      = i_in_dst_pixel;
        col      = i_in_dst_pixel;
        case (cfg.mode)
            MODE_RAW: begin
                do_write = 1'b1;
                pix      = i_in_src_pixel;
            end
            MODE_KEY: begin
                do_write = src_hit;
                pix      = src_hit ? i_in_src_pixel : i_in_dst_pixel;
            end
            MODE_TRANS: begin
                do_write = src_hit;
                use_lut  = src_hit;
            end
            MODE_XFADE: begin
                do_write = src_hit;
                use_lut  = src_hit;
                col      = i_in_object_pixel;
            end
            default: begin
                do_write = 1'b0;
            end
        endcase
        if (cfg.mask_enable && i_in_mask_bit) begin
            do_write = 1'b0;
            use_lut  = 1'b0;
            pix      = i_in_dst_pixel;
        end
    end

    assign rd_en   = blend_acc && use_lut;
    assign rd_addr = ram_addr(cfg.table_select, i_in_src_pixel, col);

    ipbe_ram #(
        .WIDTH (PIX_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in_table_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign n_s1_valid = blend_acc || (r_s1_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (blend_acc) begin
            r_s1_use_lut <= use_lut;
            r_s1_written <= do_write;
            r_s1_pix     <= pix;
        end
    end

    assign o_out_valid   = r_s1_valid;
    assign o_out_pixel   = r_s1_use_lut ? rd_data : r_s1_pix;
    assign o_out_written = r_s1_written;

    `ASSERT_NEXT(a_rd_lands, i_clk, i_rst_n, rd_en, r_s1_valid && r_s1_use_lut)
    `ASSERT_IMPL(a_lut_writes, i_clk, i_rst_n, r_s1_valid && r_s1_use_lut, r_s1_written)
    `ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, o_in_stall, r_s1_valid && i_out_stall)
    `ASSERT_IMPL(a_no_rw_mix, i_clk, i_rst_n, wr_en, !rd_en)

endmodule

@@ rtl/ipbe_ram.sv @@
// ============================================================================
// ipbe_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module ipbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/ipbe_cfg.sv @@
// ============================================================================
// ipbe_cfg
// Configuration register bank: blend mode, table select, mask enable.
// ============================================================================
`include "assert_macros.svh"

module ipbe_cfg import ipbe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [1:0] i_cfg_data,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BLEND_MODE: begin
                    n_cfg.mode = t_mode'(i_cfg_data);
                end
                CFG_TABLE_SELECT: begin
                    if (tbl_ok(i_cfg_data)) begin
                        n_cfg.table_select = i_cfg_data;
                    end
                end
                CFG_MASK_ENABLE: begin
                    n_cfg.mask_enable = i_cfg_data[0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{mode: MODE_RAW, table_select: 2'd0, mask_enable: 1'b0};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

    `ASSERT_IMPL(a_tsel_range, i_clk, i_rst_n, 1'b1, tbl_ok(r_cfg.table_select))

endmodule
